// ===== hdl/drdf_pkg.sv =====
package drdf_pkg;

	localparam int NUM_CLASSES_DEF = 20;
	localparam int NUM_ROWS_DEF    = 30;
	localparam int COORD_COUNT     = 4;

	localparam int SAMPLE_W = 24;
	localparam int SCALE_W  = 4;
	localparam int THRESH_W = 23;
	localparam int SCALED_W = 28;
	localparam int PIXEL_W  = 16;
	localparam int CLASS_W  = 5;
	localparam int COUNT_W  = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = THRESH_W;

	localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(46);
	localparam logic [SCALE_W-1:0]  SCALE_RESET  = SCALE_W'(1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCORE_THRESHOLD = 2'd0,
		REG_SCALE_X         = 2'd1,
		REG_SCALE_Y         = 2'd2
	} cfg_reg_t;

endpackage

// ===== hdl/drdf_sample_if.sv =====
interface drdf_sample_if;
	import drdf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_value;

	modport source (output valid, output sample_value, input ready);
	modport sink (input valid, input sample_value, output ready);

endinterface

// ===== hdl/drdf_box_if.sv =====
interface drdf_box_if;
	import drdf_pkg::*;

	logic                       valid;
	logic                       ready;
	logic        [PIXEL_W-1:0]  box_left;
	logic        [PIXEL_W-1:0]  box_top;
	logic signed [SCALED_W-1:0] box_width;
	logic signed [SCALED_W-1:0] box_height;
	logic        [THRESH_W-1:0] best_score;
	logic        [CLASS_W-1:0]  class_index;
	logic        [COUNT_W-1:0]  box_number;

	modport source (output valid, output box_left, output box_top, output box_width,
		output box_height, output best_score, output class_index, output box_number,
		input ready);
	modport sink (input valid, input box_left, input box_top, input box_width,
		input box_height, input best_score, input class_index, input box_number,
		output ready);

endinterface

// ===== hdl/drdf_edge.sv =====
module drdf_edge (
	input  logic signed [drdf_pkg::SCALED_W-1:0] centre,
	input  logic signed [drdf_pkg::SCALED_W-1:0] size,
	output logic        [drdf_pkg::PIXEL_W-1:0]  edge_px
);
	import drdf_pkg::*;

	localparam int TWICE_W = SCALED_W + 2;

	logic signed [TWICE_W-1:0] twice;
	logic [TWICE_W-10:0]       whole;

	// floor(centre - size/2) held exactly in Q.9
	assign twice = (TWICE_W'(centre) <<< 1) - TWICE_W'(size);
	assign whole = twice[TWICE_W-1:9];

	always_comb begin
		if (twice <= 0) begin
			edge_px = '0;
		end else if (|whole[TWICE_W-10:PIXEL_W]) begin
			edge_px = '1;
		end else begin
			edge_px = whole[PIXEL_W-1:0];
		end
	end

endmodule

// ===== hdl/detection_row_decode_filter_core.sv =====
// channel | dir | payload                                         | handshake
// sample  | in  | sample_value                                    | valid/ready
// box     | out | box_left, box_top, box_width, box_height,       | valid/ready
//         |     | best_score, class_index, box_number             |
// One value per cycle unless a waiting box stalls input; last score goes via input and result registers.
// Path: input register, coordinate scaling or running argmax, edge computation into the result register.
// arst_n clears the row, box and frame counters and the valid flags; config registers take reset values.
// A waiting box stalls input only when the next finished row also emits a box.
module detection_row_decode_filter_core #(
	parameter int NUM_CLASSES = drdf_pkg::NUM_CLASSES_DEF,
	parameter int NUM_ROWS    = drdf_pkg::NUM_ROWS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [drdf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [drdf_pkg::CFG_DATA_W-1:0]     cfg_data,
	drdf_sample_if.sink                         sample,
	drdf_box_if.source                          box
);
	import drdf_pkg::*;

	localparam int ROW_LEN = NUM_CLASSES + COORD_COUNT;
	localparam int POS_W   = $clog2(ROW_LEN);
	localparam int IDX_W   = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam int ROW_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam logic [POS_W-1:0] FIRST_SCORE = POS_W'(COORD_COUNT);
	localparam logic [POS_W-1:0] LAST_POS    = POS_W'(ROW_LEN - 1);
	localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(NUM_ROWS - 1);

	logic [THRESH_W-1:0] thresh_q;
	logic [SCALE_W-1:0]  scale_x_q;
	logic [SCALE_W-1:0]  scale_y_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;

	logic [POS_W-1:0]   pos_q;
	logic [ROW_W-1:0]   row_q;
	logic [COUNT_W-1:0] count_q;
	logic signed [SCALED_W-1:0] coord_q [COORD_COUNT];
	logic signed [SAMPLE_W-1:0] max_q;
	logic [IDX_W-1:0]           idx_q;

	logic                       out_valid_q;
	logic [PIXEL_W-1:0]         left_q;
	logic [PIXEL_W-1:0]         top_q;
	logic signed [SCALED_W-1:0] width_q;
	logic signed [SCALED_W-1:0] height_q;
	logic [THRESH_W-1:0]        score_q;
	logic [CLASS_W-1:0]         class_q;
	logic [COUNT_W-1:0]         number_q;

	logic                       is_coord;
	logic                       take_new;
	logic signed [SAMPLE_W-1:0] new_max;
	logic [POS_W-1:0]           cls_off;
	logic [IDX_W-1:0]           new_idx;
	logic                       row_end;
	logic                       emit;
	logic [SCALE_W-1:0]         scale_sel;
	logic signed [SCALED_W-1:0] prod;
	logic [PIXEL_W-1:0]         left_px;
	logic [PIXEL_W-1:0]         top_px;
	logic                       out_free;
	logic                       s1_adv;
	logic                       fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q  <= THRESH_RESET;
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_SCORE_THRESHOLD: thresh_q  <= cfg_data;
				REG_SCALE_X:         scale_x_q <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:         scale_y_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign is_coord  = pos_q < FIRST_SCORE;
	assign take_new  = (pos_q == FIRST_SCORE) || (sample_s1 > max_q);
	assign cls_off   = pos_q - FIRST_SCORE;
	assign new_max   = take_new ? sample_s1 : max_q;
	assign new_idx   = take_new ? cls_off[IDX_W-1:0] : idx_q;
	assign row_end   = !is_coord && (pos_q == LAST_POS);
	assign emit      = row_end && (new_max > $signed({1'b0, thresh_q}));
	assign scale_sel = pos_q[0] ? scale_y_q : scale_x_q;
	assign prod      = sample_s1 * $signed({1'b0, scale_sel});

	drdf_edge u_edge_x (
		.centre  (coord_q[0]),
		.size    (coord_q[2]),
		.edge_px (left_px)
	);

	drdf_edge u_edge_y (
		.centre  (coord_q[1]),
		.size    (coord_q[3]),
		.edge_px (top_px)
	);

	assign out_free     = !out_valid_q || box.ready;
	assign s1_adv       = !emit || out_free;
	assign fire         = valid_s1 && s1_adv;
	assign sample.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			pos_q       <= '0;
			row_q       <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (sample.ready) begin
				valid_s1 <= sample.valid;
			end
			if (fire) begin
				pos_q <= row_end ? '0 : pos_q + 1'b1;
				if (row_end) begin
					if (row_q == LAST_ROW) begin
						row_q   <= '0;
						count_q <= '0;
					end else begin
						row_q <= row_q + 1'b1;
						if (emit) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
			end
			if (fire && emit) begin
				out_valid_q <= 1'b1;
			end else if (box.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			sample_s1 <= sample.sample_value;
		end
		if (fire && is_coord) begin
			coord_q[pos_q[1:0]] <= prod;
		end
		if (fire && !is_coord) begin
			max_q <= new_max;
			idx_q <= new_idx;
		end
		if (fire && emit) begin
			left_q   <= left_px;
			top_q    <= top_px;
			width_q  <= coord_q[2];
			height_q <= coord_q[3];
			score_q  <= new_max[THRESH_W-1:0];
			class_q  <= CLASS_W'(new_idx);
			number_q <= count_q;
		end
	end

	assign box.valid       = out_valid_q;
	assign box.box_left    = left_q;
	assign box.box_top     = top_q;
	assign box.box_width   = width_q;
	assign box.box_height  = height_q;
	assign box.best_score  = score_q;
	assign box.class_index = class_q;
	assign box.box_number  = number_q;

endmodule

// ===== sim/tb_detection_row_decode_filter_core.sv =====
`timescale 1ns / 100ps

module tb_detection_row_decode_filter_core;
	import drdf_pkg::*;

	localparam int ROW_LEN = NUM_CLASSES_DEF + COORD_COUNT;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_MISMATCHES = 10;
	localparam int MAX_WAIT = 13;
	localparam int EDGE_SHIFT = 9;
	localparam int SAMPLE_MIN = -8388608;
	localparam int SAMPLE_MAX = 8388607;
	localparam int ROWS_PER_PHASE = 11;
	localparam int PHASES = 6;
	localparam int DIRECTED_COUNT = 9;
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;
	localparam logic [THRESH_W-1:0] THRESH_MAX = {THRESH_W{1'b1}};
	localparam logic [SCALE_W-1:0] SCALE_MAX = {SCALE_W{1'b1}};

	typedef struct packed {
		logic [PIXEL_W-1:0] left;
		logic [PIXEL_W-1:0] top;
		logic signed [SCALED_W-1:0] width;
		logic signed [SCALED_W-1:0] height;
		logic [THRESH_W-1:0] score;
		logic [CLASS_W-1:0] cls;
		logic [COUNT_W-1:0] num;
	} box_t;

	typedef struct {
		bit typed;
		bit emits;
		box_t want;
	} row_check_t;

	typedef struct {
		logic [THRESH_W-1:0] thr;
		logic [SCALE_W-1:0] sx;
		logic [SCALE_W-1:0] sy;
		int cx;
		int cy;
		int w;
		int h;
		int win_cls;
		int win;
		int rest;
		int tie_cls;
		bit typed;
		bit emits;
		box_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	drdf_sample_if sample_ch();
	drdf_box_if box_ch();

	detection_row_decode_filter_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.sample(sample_ch),
		.box(box_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [THRESH_W-1:0] thr_cfg = THRESH_RESET;
	logic [SCALE_W-1:0] sx_cfg = SCALE_RESET;
	logic [SCALE_W-1:0] sy_cfg = SCALE_RESET;
	int pos_in_row = 0;
	int row_count = 0;
	logic [COUNT_W-1:0] boxes_in_frame = '0;
	longint coord [COORD_COUNT];
	longint best_val = 0;
	int best_cls = 0;

	box_t pending_boxes [$];
	row_check_t row_checks [$];
	directed_row_t directed_rows [DIRECTED_COUNT];
	int row_buf [ROW_LEN];
	int mismatches = 0;
	int cycles = 0;
	bit steady_in = 1'b0;
	bit steady_out = 1'b0;

	function automatic logic [PIXEL_W-1:0] pixel_edge(input longint centre, input longint size);
		longint twice;
		twice = 2 * centre - size;
		if (twice <= 0)
			return '0;
		if ((twice >>> EDGE_SHIFT) > longint'({PIXEL_W{1'b1}}))
			return '1;
		return PIXEL_W'(twice >>> EDGE_SHIFT);
	endfunction

	function automatic int clip24(input longint v);
		if (v < SAMPLE_MIN)
			return SAMPLE_MIN;
		if (v > SAMPLE_MAX)
			return SAMPLE_MAX;
		return int'(v);
	endfunction

	function automatic int pick_coord();
		case ($urandom_range(0, 15))
			0: return SAMPLE_MIN;
			1: return SAMPLE_MAX;
			2: return int'($urandom);
			3: return -int'($urandom_range(0, 25600));
			default: return int'($urandom_range(0, 163840));
		endcase
	endfunction

	task automatic decode_sample(input logic signed [SAMPLE_W-1:0] v);
		box_t b;
		row_check_t rc;
		longint x, y, w, h;
		bit emits;
		if (pos_in_row < COORD_COUNT) begin
			coord[pos_in_row] = longint'(v);
			pos_in_row++;
		end else begin
			if (pos_in_row == COORD_COUNT || longint'(v) > best_val) begin
				best_val = longint'(v);
				best_cls = pos_in_row - COORD_COUNT;
			end
			if (pos_in_row + 1 < ROW_LEN) begin
				pos_in_row++;
			end else begin
				pos_in_row = 0;
				emits = best_val > longint'(thr_cfg);
				x = coord[0] * longint'(sx_cfg);
				y = coord[1] * longint'(sy_cfg);
				w = coord[2] * longint'(sx_cfg);
				h = coord[3] * longint'(sy_cfg);
				b.left = pixel_edge(x, w);
				b.top = pixel_edge(y, h);
				b.width = SCALED_W'(w);
				b.height = SCALED_W'(h);
				b.score = THRESH_W'(best_val);
				b.cls = CLASS_W'(best_cls);
				b.num = boxes_in_frame;
				if (emits)
					boxes_in_frame++;
				row_count++;
				if (row_count >= NUM_ROWS_DEF) begin
					row_count = 0;
					boxes_in_frame = '0;
				end
				rc.typed = 1'b0;
				rc.emits = 1'b0;
				rc.want = '0;
				if (row_checks.size() > 0)
					rc = row_checks.pop_front();
				if (rc.typed) begin
					if (rc.emits)
						pending_boxes.push_back(rc.want);
				end else if (emits) begin
					pending_boxes.push_back(b);
				end
			end
		end
	endtask

	task automatic check_box(input box_t got);
		box_t want;
		if (pending_boxes.size() == 0) begin
			mismatches++;
			if (mismatches <= SHOWN_MISMATCHES)
				$display("unexpected box: left=%0d top=%0d w=%0d h=%0d score=%0d class=%0d num=%0d",
					got.left, got.top, got.width, got.height, got.score, got.cls, got.num);
		end else begin
			want = pending_boxes.pop_front();
			if (got.left !== want.left || got.top !== want.top || got.width !== want.width ||
					got.height !== want.height || got.score !== want.score ||
					got.cls !== want.cls || got.num !== want.num) begin
				mismatches++;
				if (mismatches <= SHOWN_MISMATCHES) begin
					$display("box mismatch: expected left=%0d top=%0d w=%0d h=%0d score=%0d class=%0d num=%0d",
						want.left, want.top, want.width, want.height, want.score, want.cls,
						want.num);
					$display("                actual left=%0d top=%0d w=%0d h=%0d score=%0d class=%0d num=%0d",
						got.left, got.top, got.width, got.height, got.score, got.cls, got.num);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_ch.valid && sample_ch.ready)
				decode_sample(sample_ch.sample_value);
			if (box_ch.valid && box_ch.ready)
				check_box('{box_ch.box_left, box_ch.box_top, box_ch.box_width, box_ch.box_height,
					box_ch.best_score, box_ch.class_index, box_ch.box_number});
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int stall;
		box_ch.ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 7) == 0)
				steady_out = !steady_out;
			stall = steady_out ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				box_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			box_ch.ready = 1'b1;
			do @(posedge clk); while (!box_ch.valid);
			@(negedge clk);
		end
	end

	task automatic push_sample(input int v);
		int gap;
		if ($urandom_range(0, 63) == 0)
			steady_in = !steady_in;
		gap = steady_in ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			sample_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		sample_ch.valid = 1'b1;
		sample_ch.sample_value = SAMPLE_W'(v);
		do @(posedge clk); while (!sample_ch.ready);
		@(negedge clk);
	endtask

	task automatic send_row();
		for (int i = 0; i < ROW_LEN; i++)
			push_sample(row_buf[i]);
	endtask

	task automatic wait_idle();
		sample_ch.valid = 1'b0;
		while (pending_boxes.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_wen = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_wen = 1'b0;
		case (idx)
			REG_SCORE_THRESHOLD: thr_cfg = data;
			REG_SCALE_X: sx_cfg = data[SCALE_W-1:0];
			REG_SCALE_Y: sy_cfg = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(input logic [THRESH_W-1:0] thr, input logic [SCALE_W-1:0] sx,
			input logic [SCALE_W-1:0] sy);
		wait_idle();
		write_reg(REG_SCORE_THRESHOLD, thr);
		write_reg(REG_SCALE_X, CFG_DATA_W'(sx));
		write_reg(REG_SCALE_Y, CFG_DATA_W'(sy));
	endtask

	task automatic build_random_row();
		int t, win, tie;
		t = int'(thr_cfg);
		if ($urandom_range(0, 9) == 0) begin
			for (int i = 0; i < ROW_LEN; i++)
				row_buf[i] = int'($urandom);
		end else begin
			for (int i = 0; i < COORD_COUNT; i++)
				row_buf[i] = pick_coord();
			case ($urandom_range(0, 7))
				0: win = t;
				1: win = clip24(longint'(t) - $urandom_range(1, 100000));
				default: win = clip24(longint'(t) + $urandom_range(1, 20000));
			endcase
			for (int c = 0; c < NUM_CLASSES_DEF; c++) begin
				if ($urandom_range(0, 3) == 0)
					row_buf[COORD_COUNT + c] = int'($urandom);
				else
					row_buf[COORD_COUNT + c] = clip24(longint'(win) - $urandom_range(0, 50000));
			end
			row_buf[COORD_COUNT + $urandom_range(0, NUM_CLASSES_DEF - 1)] = win;
			if ($urandom_range(0, 3) == 0) begin
				tie = $urandom_range(0, NUM_CLASSES_DEF - 1);
				row_buf[COORD_COUNT + tie] = win;
			end
		end
	endtask

	initial begin
		directed_row_t d;
		logic [THRESH_W-1:0] thr;
		logic [SCALE_W-1:0] sx, sy;
		row_check_t rc;

		directed_rows = '{
			'{46, 1, 1, 25600, 12800, 5120, 2560, 3, 256, 0, -1, 1'b1, 1'b1,
				'{16'd90, 16'd45, 28'sd5120, 28'sd2560, 23'd256, 5'd3, 5'd0}},
			'{46, 1, 1, 1000, 2000, 300, 400, 9, 46, -100, -1, 1'b1, 1'b0, '0},
			'{46, 1, 1, SAMPLE_MIN, SAMPLE_MAX, 0, SAMPLE_MIN, 19, 47, 46, -1, 1'b1, 1'b1,
				'{16'd0, 16'd49151, 28'sd0, -28'sd8388608, 23'd47, 5'd19, 5'd1}},
			'{46, 1, 1, 163840, 76800, 12800, 25600, 5, 1000, 10, 12, 1'b0, 1'b0, '0},
			'{46, 1, 1, 0, 0, 0, 0, 0, SAMPLE_MIN, SAMPLE_MIN, -1, 1'b1, 1'b0, '0},
			'{0, SCALE_MAX, SCALE_MAX, SAMPLE_MAX, SAMPLE_MAX, 0, 0, 0, 1, -5, -1, 1'b1, 1'b1,
				'{16'd65535, 16'd65535, 28'sd0, 28'sd0, 23'd1, 5'd0, 5'd3}},
			'{0, 0, 0, 12345, -2222, 777, -999, 7, 1, 0, -1, 1'b1, 1'b1,
				'{16'd0, 16'd0, 28'sd0, 28'sd0, 23'd1, 5'd7, 5'd4}},
			'{THRESH_MAX, 1, 1, 2560, 2560, 256, 256, 0, SAMPLE_MAX, SAMPLE_MAX, -1, 1'b1, 1'b0,
				'0},
			'{46, 1, 1, SAMPLE_MAX, 100, SAMPLE_MIN, -1, 0, SAMPLE_MAX, SAMPLE_MAX, -1, 1'b0,
				1'b0, '0}
		};

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_SCORE_THRESHOLD;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.sample_value = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_UNMAPPED, CFG_DATA_W'($urandom));

		for (int k = 0; k < DIRECTED_COUNT; k++) begin
			d = directed_rows[k];
			if (d.thr != thr_cfg || d.sx != sx_cfg || d.sy != sy_cfg)
				apply_settings(d.thr, d.sx, d.sy);
			rc.typed = d.typed;
			rc.emits = d.emits;
			rc.want = d.want;
			row_checks.push_back(rc);
			row_buf[0] = d.cx;
			row_buf[1] = d.cy;
			row_buf[2] = d.w;
			row_buf[3] = d.h;
			for (int c = 0; c < NUM_CLASSES_DEF; c++)
				row_buf[COORD_COUNT + c] = (c == d.win_cls || c == d.tie_cls) ? d.win : d.rest;
			send_row();
		end

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin thr = THRESH_RESET; sx = SCALE_RESET; sy = SCALE_RESET; end
				1: begin thr = '0; sx = SCALE_MAX; sy = SCALE_MAX; end
				2: begin thr = THRESH_MAX; sx = 4'd7; sy = 4'd2; end
				3: begin
					thr = THRESH_W'($urandom_range(0, 3000));
					sx = SCALE_W'($urandom_range(0, 15));
					sy = SCALE_W'($urandom_range(0, 15));
				end
				4: begin thr = '0; sx = '0; sy = SCALE_MAX; end
				default: begin
					thr = THRESH_W'($urandom);
					sx = SCALE_W'($urandom_range(0, 15));
					sy = SCALE_W'($urandom_range(0, 15));
				end
			endcase
			apply_settings(thr, sx, sy);
			for (int r = 0; r < ROWS_PER_PHASE; r++) begin
				build_random_row();
				send_row();
			end
		end

		sample_ch.valid = 1'b0;
		while (pending_boxes.size() > 0)
			@(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_boxes.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== detection_row_decode_filter_core.f =====
hdl/drdf_pkg.sv
hdl/drdf_sample_if.sv
hdl/drdf_box_if.sv
hdl/drdf_edge.sv
hdl/detection_row_decode_filter_core.sv
sim/tb_detection_row_decode_filter_core.sv
